### src/apra_pkg.sv
`default_nettype none

package apra_pkg;

  // Fixed geometry of a page and of one bitmap row.
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int ROW_BITS   = 16;
  localparam int ROW_SHIFT  = $clog2(ROW_BITS);

  localparam logic [3:0] MAX_BLOCK_ORDER = 4'd10;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ORDER    = 2'd1;
  localparam logic [1:0] ST_NO_BLOCK = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS_OFFSET = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAGES_IN_USE   = 2'd1;

  localparam int PIU_W = 13;

  typedef struct packed {
    logic        kind;
    logic [3:0]  block_order;
    logic [63:0] block_address;
  } req_t;

  typedef struct packed {
    logic [63:0] granted_address;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic decode;
    logic chk_fail;
    logic no_fit;
    logic scan_init;
    logic scan_next;
    logic mark_init;
    logic mark_write;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic chk_fail;
    logic is_alloc;
    logic found;
    logic scan_end;
    logic mark_last;
    logic res_room;
  } stat_t;

endpackage

`default_nettype wire

### src/apra_ctrl.sv
`default_nettype none

module apra_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_stall,
  input  apra_pkg::stat_t  stat,
  output apra_pkg::cmd_t   cmd
);
  import apra_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_DECODE   = 9'b000000100,
    S_CHECK    = 9'b000001000,
    S_SCAN_RD  = 9'b000010000,
    S_SCAN_CHK = 9'b000100000,
    S_MARK_RD  = 9'b001000000,
    S_MARK_WR  = 9'b010000000,
    S_RESULT   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.chk_fail) begin
          cmd.chk_fail = 1'b1;
          state_next   = S_RESULT;
        end else if (stat.is_alloc) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN_RD;
        end else begin
          cmd.mark_init = 1'b1;
          state_next    = S_MARK_RD;
        end
      end
      // The row address is already on the memory; this cycle waits for its data.
      S_SCAN_RD: begin
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (stat.found) begin
          cmd.mark_init = 1'b1;
          state_next    = S_MARK_RD;
        end else if (stat.scan_end) begin
          cmd.no_fit = 1'b1;
          state_next = S_RESULT;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_MARK_RD: begin
        state_next = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd.mark_write = 1'b1;
        state_next     = stat.mark_last ? S_RESULT : S_MARK_RD;
      end
      S_RESULT: begin
        if (stat.res_room) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/apra_dpath.sv
`default_nettype none

module apra_dpath #(
  parameter int PAGES = 4096
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  apra_pkg::cmd_t                       cmd,
  output apra_pkg::stat_t                      stat,
  input  apra_pkg::req_t                       req,
  input  wire                                  cfg_valid,
  input  wire  [apra_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [63:0]                          cfg_data,
  output logic                                 rsp_valid,
  input  wire                                  rsp_stall,
  output apra_pkg::rsp_t                       rsp
);
  import apra_pkg::*;

  localparam int ROWS = (PAGES + ROW_BITS - 1) / ROW_BITS;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PW   = RW + ROW_SHIFT;
  localparam int AW   = ((PW > 16) ? PW : 16) + 2;
  localparam int AVW  = ROW_SHIFT + 1;
  localparam int FW   = ROW_SHIFT + 2;

  logic [ROW_BITS-1:0] mem [ROWS];

  logic [63:0]         offset_q;
  logic [PIU_W-1:0]    piu_q;
  logic                kind_q;
  logic [3:0]          order_q;
  logic [63:0]         addr_q;
  logic [63:0]         local_q;
  logic [RW-1:0]       row;
  logic [RW-1:0]       last_row;
  logic [PW-1:0]       pfn_q;
  logic                blk_ok;
  logic [1:0]          res_status;
  logic [ROW_BITS-1:0] rdata;

  logic [AW-1:0]       count;
  logic [AW-1:0]       len;
  logic                order_big;
  logic [AW-1:0]       rb;
  logic [AW-1:0]       diff;
  logic [AVW-1:0]      avail;
  logic                small_run;
  logic [ROW_BITS:0]   lenmask_w;
  logic [ROW_BITS-1:0] lenmask;
  logic [ROW_BITS-1:0] hit;
  logic [ROW_SHIFT-1:0] hit_idx;
  logic [AW-1:0]       rmask;
  logic [AW-1:0]       row_aw;
  logic                first_row;
  logic                end_row;
  logic                row_full;
  logic                ok_now;
  logic [AW-1:0]       found_pfn;
  logic [63:0]         pfn64;
  logic                chk_fail;
  logic [1:0]          chk_code;
  logic [AW-1:0]       pfn_src;
  logic [AW-1:0]       end_src;
  logic [AW-1:0]       pfn_aw;
  logic [AW-1:0]       pend;
  logic [AW-1:0]       pg;
  logic [ROW_BITS-1:0] mark_mask;
  logic [ROW_BITS-1:0] wdata;
  logic                mem_we;
  logic [ROW_BITS-1:0] mem_wdata;

  always_comb begin
    count     = (AW'(piu_q) > AW'(PAGES)) ? AW'(PAGES) : AW'(piu_q);
    len       = AW'(1) << order_q;
    order_big = (order_q > MAX_BLOCK_ORDER);
    small_run = (order_q <= 4'(ROW_SHIFT));
    row_aw    = AW'(row);
    rb        = row_aw << ROW_SHIFT;

    // Pages of this row that still lie below the managed count.
    diff = count - rb;
    if (count <= rb) begin
      avail = '0;
    end else if (diff >= AW'(ROW_BITS)) begin
      avail = AVW'(ROW_BITS);
    end else begin
      avail = diff[AVW-1:0];
    end

    lenmask_w = ((ROW_BITS+1)'(1) << len[ROW_SHIFT:0]) - (ROW_BITS+1)'(1);
    lenmask   = lenmask_w[ROW_BITS-1:0];

    hit = '0;
    for (int b = 0; b < ROW_BITS; b++) begin
      hit[b] = ((ROW_SHIFT'(b) & ROW_SHIFT'(len - AW'(1))) == '0)
               && (&((rdata >> b) | ~lenmask))
               && (FW'(b) + FW'(len[ROW_SHIFT:0]) <= FW'(avail));
    end
    hit_idx = '0;
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (hit[b]) begin
        hit_idx = ROW_SHIFT'(b);
      end
    end

    // A run longer than a row covers an aligned group of whole rows.
    rmask     = (AW'(1) << (order_q - 4'(ROW_SHIFT))) - AW'(1);
    first_row = ((row_aw & rmask) == '0);
    end_row   = ((row_aw & rmask) == rmask);
    row_full  = (&rdata) && (avail == AVW'(ROW_BITS));
    ok_now    = (first_row || blk_ok) && row_full;

    if (small_run) begin
      stat.found = |hit;
      found_pfn  = rb + AW'(hit_idx);
    end else begin
      stat.found = end_row && ok_now;
      found_pfn  = (row_aw & ~rmask) << ROW_SHIFT;
    end
    stat.scan_end = (rb + AW'(ROW_BITS) >= count);

    pfn64    = local_q >> PAGE_SHIFT;
    chk_fail = 1'b0;
    chk_code = ST_OK;
    if (kind_q == KIND_ALLOC) begin
      if (order_big) begin
        chk_fail = 1'b1;
        chk_code = ST_ORDER;
      end else if (len > count) begin
        chk_fail = 1'b1;
        chk_code = ST_NO_BLOCK;
      end
    end else begin
      if (local_q == '0 || order_big || len > count) begin
        chk_fail = 1'b1;
        chk_code = ST_IGNORED;
      end else if (pfn64 > 64'(count - len)) begin
        chk_fail = 1'b1;
        chk_code = ST_IGNORED;
      end
    end

    pfn_src = (kind_q == KIND_ALLOC) ? found_pfn : AW'(pfn64[PW-1:0]);
    end_src = pfn_src + len - AW'(1);

    pfn_aw = AW'(pfn_q);
    pend   = pfn_aw + len;
    pg     = '0;
    for (int b = 0; b < ROW_BITS; b++) begin
      pg           = rb + AW'(b);
      mark_mask[b] = (pg >= pfn_aw) && (pg < pend);
    end
    wdata = (kind_q == KIND_FREE) ? (rdata | mark_mask) : (rdata & ~mark_mask);

    mem_we    = cmd.clear || cmd.mark_write;
    mem_wdata = cmd.clear ? '0 : wdata;

    stat.clear_last = (row == RW'(ROWS - 1));
    stat.chk_fail   = chk_fail;
    stat.is_alloc   = (kind_q == KIND_ALLOC);
    stat.mark_last  = (row == last_row);
    stat.res_room   = !rsp_valid || !rsp_stall;
  end

  // The bitmap is read at the current row every cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[row] <= mem_wdata;
    end
    rdata <= mem[row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_q   <= '0;
      piu_q      <= '0;
      row        <= '0;
      blk_ok     <= 1'b0;
      res_status <= ST_OK;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ADDRESS_OFFSET: offset_q <= cfg_data;
          REG_PAGES_IN_USE:   piu_q    <= cfg_data[PIU_W-1:0];
          default: ;
        endcase
      end

      if (cmd.clear) begin
        row <= stat.clear_last ? '0 : row + RW'(1);
      end else if (cmd.scan_init) begin
        row    <= '0;
        blk_ok <= 1'b0;
      end else if (cmd.scan_next) begin
        row    <= row + RW'(1);
        blk_ok <= ok_now;
      end else if (cmd.mark_init) begin
        row        <= RW'(pfn_src >> ROW_SHIFT);
        res_status <= ST_OK;
      end else if (cmd.mark_write) begin
        row <= row + RW'(1);
      end else if (cmd.chk_fail) begin
        res_status <= chk_code;
      end else if (cmd.no_fit) begin
        res_status <= ST_NO_BLOCK;
      end

      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= req.kind;
      order_q <= req.block_order;
      addr_q  <= req.block_address;
    end
    if (cmd.decode) begin
      local_q <= addr_q - offset_q;
    end
    if (cmd.mark_init) begin
      pfn_q    <= PW'(pfn_src);
      last_row <= RW'(end_src >> ROW_SHIFT);
    end
    if (cmd.emit) begin
      rsp.status <= res_status;
      if (res_status == ST_OK && kind_q == KIND_ALLOC) begin
        rsp.granted_address <= (64'(pfn_q) << PAGE_SHIFT) + offset_q;
      end else begin
        rsp.granted_address <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### src/aligned_page_run_allocator_core.sv
// Steps: decode and range check, then a read and a check state per bitmap row scanned
// (16 pages a row, first-fit from page 0), a read and a write state per row marked,
// and a result state that loads the result register. One request is handled at a time.
// The result register lets the next request start while the previous beat waits to be taken.
// Reset (rst, synchronous) zeroes the configuration, row and status registers and then clears the
// bitmap, ceil(PAGES/16) rows (256 by default), during which no request is accepted.
`default_nettype none

module aligned_page_run_allocator_core #(
  parameter int PAGES = 4096
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 req_valid,
  output logic                                req_stall,
  input  apra_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  wire                                 rsp_stall,
  output apra_pkg::rsp_t                      rsp,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [apra_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [63:0]                         cfg_data
);
  import apra_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  apra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  apra_dpath #(
    .PAGES (PAGES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
